// ----- rtl/core/brf_pkg.sv -----
package brf_pkg;

  localparam int OPC_W  = 3;
  localparam int BYTE_W = 8;
  localparam int OFS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int SZ_W   = 9;
  localparam int ST_W   = 2;

  // operation codes
  localparam logic [OPC_W-1:0] OP_WRITE      = 3'd0;
  localparam logic [OPC_W-1:0] OP_READ       = 3'd1;
  localparam logic [OPC_W-1:0] OP_PEEK       = 3'd2;
  localparam logic [OPC_W-1:0] OP_DROP_FRONT = 3'd3;
  localparam logic [OPC_W-1:0] OP_DROP_BACK  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  localparam logic [SZ_W-1:0] RING_SIZE_RST = 9'd256;

endpackage

// ----- rtl/core/brf_channels.sv -----
interface brf_in_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [BYTE_W-1:0] data_byte;
  logic [OFS_W-1:0]  peek_offset;
  logic [CNT_W-1:0]  erase_count;

  modport source (output valid, opcode, data_byte, peek_offset, erase_count, input ready);
  modport sink   (input valid, opcode, data_byte, peek_offset, erase_count, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic [ST_W-1:0]   status;
  logic [SZ_W-1:0]   used_count;
  logic [SZ_W-1:0]   free_count;

  modport source (output valid, read_byte, status, used_count, free_count, input ready);
  modport sink   (input valid, read_byte, status, used_count, free_count, output ready);
endinterface

interface brf_cfg_if import brf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SZ_W-1:0] ring_size;

  modport source (output valid, ring_size, input ready);
  modport sink   (input valid, ring_size, output ready);
endinterface

// ----- rtl/core/brf_ring_ram.sv -----
module brf_ring_ram import brf_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [BYTE_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [BYTE_W-1:0]        rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/byte_ring_fifo_peek_trim_unit.sv -----
// Channel   Dir  Handshake       Payload
// in_if     in   valid / ready   opcode, data_byte, peek_offset, erase_count
// out_if    out  valid / ready   read_byte, status, used_count, free_count
// cfg_if    in   valid / ready   ring_size (cfg_if.ready is always high)
//
// In the accept cycle a transaction updates the pointers, writes the ring
// RAM and issues its read; its result is parked, and when the output
// register frees, the registered RAM data moves into the output register.
// A new transaction is taken in the cycle in which that parked result
// moves, so the unit sustains one transaction per cycle while out_if drains.
// A stalled output holds the finished result; one more transaction is then
// accepted and parked until the output register frees.
// Reset (rst_n low, synchronous) empties the ring and sets ring_size to 256;
// the RAM contents are not cleared, and no clearing pass is needed.
module byte_ring_fifo_peek_trim_unit import brf_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_if,
  brf_out_if.source out_if,
  brf_cfg_if.sink   cfg_if
);

  // The ring size register is 9 bits, so no pointer ever goes past 510.
  localparam int SIZE_MAX = (DEPTH < 511) ? DEPTH : 511;
  localparam int PW       = $clog2(SIZE_MAX);
  localparam int AW       = $clog2(DEPTH);

  typedef enum logic {S_IDLE, S_FIN} state_t;

  state_t            state_r;
  logic [SZ_W-1:0]   ring_size_r;
  logic [PW-1:0]     wp_r, rp_r;
  logic              full_r;

  // parked result of the transaction in flight
  logic [ST_W-1:0]   pend_status_r;
  logic [SZ_W-1:0]   pend_used_r;
  logic [SZ_W-1:0]   pend_free_r;
  logic              pend_rd_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [ST_W-1:0]   out_status_r;
  logic [SZ_W-1:0]   out_used_r;
  logic [SZ_W-1:0]   out_free_r;

  // next-state values for an accepted transaction
  logic [PW-1:0]     wp_nxt, rp_nxt;
  logic              full_nxt;
  logic [ST_W-1:0]   status_nxt;
  logic              rd_nxt;
  logic [PW-1:0]     rd_ptr;
  logic [SZ_W-1:0]   used_nxt;

  logic [SZ_W-1:0]   size_eff;
  logic [SZ_W-1:0]   wp9, rp9, used_now;
  logic [SZ_W:0]     peek_sum, peek_wrap, front_sum, front_wrap;
  logic [SZ_W-1:0]   wp_inc;

  logic              acc_in, acc_cfg, slot_free, load_out, ram_we, ram_re;
  logic [BYTE_W-1:0] ram_q;

  function automatic logic [SZ_W-1:0] used_of(input logic            full,
                                              input logic [SZ_W-1:0] wp,
                                              input logic [SZ_W-1:0] rp,
                                              input logic [SZ_W-1:0] size);
    logic [SZ_W-1:0] u;
    if (full) begin
      u = size;
    end else if (wp >= rp) begin
      u = wp - rp;
    end else begin
      u = size - rp + wp;
    end
    return u;
  endfunction

  assign acc_in    = in_if.valid && in_if.ready;
  assign acc_cfg   = cfg_if.valid && cfg_if.ready;
  assign slot_free = !out_valid_r || out_if.ready;
  assign load_out  = (state_r == S_FIN) && slot_free;

  assign in_if.ready  = (state_r == S_IDLE) || slot_free;
  assign cfg_if.ready = 1'b1;

  // Clamp the ring size: zero acts as one, anything above DEPTH as DEPTH.
  always_comb begin
    if (ring_size_r == '0) begin
      size_eff = SZ_W'(1);
    end else if (32'(ring_size_r) > DEPTH) begin
      size_eff = SZ_W'(DEPTH);
    end else begin
      size_eff = ring_size_r;
    end
  end

  assign wp9      = SZ_W'(wp_r);
  assign rp9      = SZ_W'(rp_r);
  assign used_now = used_of(full_r, wp9, rp9, size_eff);

  // Sums stay below twice the ring size, so one subtract wraps them.
  assign wp_inc     = (wp9 + SZ_W'(1) == size_eff) ? '0 : wp9 + SZ_W'(1);
  assign peek_sum   = {1'b0, rp9} + (SZ_W+1)'(in_if.peek_offset);
  assign peek_wrap  = (peek_sum >= {1'b0, size_eff}) ? peek_sum - {1'b0, size_eff} : peek_sum;
  assign front_sum  = {1'b0, rp9} + {1'b0, in_if.erase_count};
  assign front_wrap = (front_sum >= {1'b0, size_eff}) ? front_sum - {1'b0, size_eff} : front_sum;

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    full_nxt   = full_r;
    status_nxt = ST_OK;
    rd_nxt     = 1'b0;
    rd_ptr     = rp_r;
    ram_we     = 1'b0;
    case (in_if.opcode)
      OP_WRITE: begin
        if (full_r) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we   = acc_in;
          wp_nxt   = PW'(wp_inc);
          full_nxt = (PW'(wp_inc) == rp_r);
        end
      end
      OP_READ: begin
        if (used_now == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_nxt   = 1'b1;
          rp_nxt   = PW'((rp9 + SZ_W'(1) == size_eff) ? '0 : rp9 + SZ_W'(1));
          full_nxt = 1'b0;
        end
      end
      OP_PEEK: begin
        if (used_now == '0) begin
          status_nxt = ST_EMPTY;
        end else if (SZ_W'(in_if.peek_offset) >= used_now) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = 1'b1;
          rd_ptr = PW'(peek_wrap);
        end
      end
      OP_DROP_FRONT: begin
        if (in_if.erase_count == '0 || in_if.erase_count >= used_now) begin
          rp_nxt = wp_r;
        end else begin
          rp_nxt = PW'(front_wrap);
        end
        full_nxt = 1'b0;
      end
      OP_DROP_BACK: begin
        if (in_if.erase_count == '0 || in_if.erase_count >= used_now) begin
          rp_nxt = wp_r;
        end else if (wp9 >= in_if.erase_count) begin
          wp_nxt = PW'(wp9 - in_if.erase_count);
        end else begin
          // wrap below zero: the count exceeds the head, so the head goes back from the top of the ring
          wp_nxt = PW'(size_eff - (in_if.erase_count - wp9));
        end
        full_nxt = 1'b0;
      end
      default: begin
        // unknown opcode: report counts, change nothing
      end
    endcase
  end

  assign used_nxt = used_of(full_nxt, SZ_W'(wp_nxt), SZ_W'(rp_nxt), size_eff);
  assign ram_re   = acc_in && rd_nxt;

  brf_ring_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wp_r)),
    .wdata (in_if.data_byte),
    .re    (ram_re),
    .raddr (AW'(rd_ptr)),
    .rdata (ram_q)
  );

  // Pointers and ring size; a configuration write empties the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      wp_r        <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
    end else if (acc_cfg) begin
      ring_size_r <= cfg_if.ring_size;
      wp_r        <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
    end else if (acc_in) begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      full_r      <= full_nxt;
    end
  end

  // Sequencer with parked result and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_in) begin
        state_r <= S_FIN;
      end else if (load_out) begin
        state_r <= S_IDLE;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      // park the result of the accepted transaction
      if (acc_in) begin
        pend_status_r <= status_nxt;
        pend_used_r   <= used_nxt;
        pend_free_r   <= size_eff - used_nxt;
        pend_rd_r     <= rd_nxt;
      end

      // advance the parked result, merging the RAM data for read and peek
      if (load_out) begin
        out_byte_r   <= pend_rd_r ? ram_q : '0;
        out_status_r <= pend_status_r;
        out_used_r   <= pend_used_r;
        out_free_r   <= pend_free_r;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_byte  = out_byte_r;
  assign out_if.status     = out_status_r;
  assign out_if.used_count = out_used_r;
  assign out_if.free_count = out_free_r;

endmodule

// ----- tb/tb_byte_ring_fifo_peek_trim_unit.sv -----
module tb_byte_ring_fifo_peek_trim_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 40;
  localparam int HOLD_CYCLES  = 300;

  // Opcodes outside the defined set; the block must treat them as no-ops.
  localparam logic [OPC_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [ST_W-1:0]   status;
    logic [SZ_W-1:0]   used_count;
    logic [SZ_W-1:0]   free_count;
  } fifo_outcome_t;

  typedef enum int unsigned {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  brf_in_if  in_ch();
  brf_out_if out_ch();
  brf_cfg_if cfg_ch();

  byte_ring_fifo_peek_trim_unit #(.DEPTH(RING_DEPTH)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the ring: contents, head (write side), tail (read side),
  // full flag and the programmed size register.
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned       head_ptr = 0;
  int unsigned       tail_ptr = 0;
  bit                ring_full = 1'b0;
  logic [SZ_W-1:0]   ring_size_reg = RING_SIZE_RST;

  // Outcomes of accepted transactions, oldest first.
  fifo_outcome_t pending_outcomes[$];

  int unsigned error_count  = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  bit          sender_gaps  = 1'b1;

  // Long receiver hold-off: bump hold_token to request hold_len stalled cycles.
  int unsigned hold_len   = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  rx_mode_e          rx_mode    = RX_STEADY;
  int unsigned       rx_left    = 0;
  int unsigned       rx_phase   = 0;
  logic [7:0]        rx_pattern = 8'hFF;

  // ---------------------------------------------------------------------------
  // Ring arithmetic
  // ---------------------------------------------------------------------------

  // A size of zero acts as one entry, anything above the depth as the depth.
  function automatic int unsigned ring_span();
    if (ring_size_reg == '0) return 1;
    if (ring_size_reg > RING_DEPTH) return RING_DEPTH;
    return ring_size_reg;
  endfunction

  function automatic int unsigned bytes_held(input int unsigned span);
    if (ring_full) return span;
    if (head_ptr >= tail_ptr) return head_ptr - tail_ptr;
    return span - tail_ptr + head_ptr;
  endfunction

  // Any size write empties the ring; stored bytes stay where they are.
  function automatic void apply_ring_size(input logic [SZ_W-1:0] value);
    ring_size_reg = value;
    head_ptr      = 0;
    tail_ptr      = 0;
    ring_full     = 1'b0;
  endfunction

  // Advance the shadow ring by one operation and return what the block owes.
  function automatic fifo_outcome_t fifo_op_outcome(input logic [OPC_W-1:0]  op,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [OFS_W-1:0]  ofs,
                                                    input logic [CNT_W-1:0]  cnt);
    int unsigned   span;
    int unsigned   held;
    fifo_outcome_t res;
    span       = ring_span();
    held       = bytes_held(span);
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_WRITE: begin
        if (ring_full) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[head_ptr] = data;
          head_ptr = (head_ptr + 1) % span;
          if (head_ptr == tail_ptr) ring_full = 1'b1;
        end
      end
      OP_READ: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_byte = ring_mem[tail_ptr];
          tail_ptr  = (tail_ptr + 1) % span;
          ring_full = 1'b0;
        end
      end
      OP_PEEK: begin
        if (held == 0) res.status = ST_EMPTY;
        else if (ofs >= held) res.status = ST_RANGE;
        else res.read_byte = ring_mem[(tail_ptr + ofs) % span];
      end
      OP_DROP_FRONT: begin
        if (cnt == 0 || cnt >= held) tail_ptr = head_ptr;
        else tail_ptr = (tail_ptr + cnt) % span;
        ring_full = 1'b0;
      end
      OP_DROP_BACK: begin
        if (cnt == 0 || cnt >= held) tail_ptr = head_ptr;
        else if (head_ptr >= cnt) head_ptr = head_ptr - cnt;
        else head_ptr = span - (cnt - head_ptr);
        ring_full = 1'b0;
      end
      default: ;
    endcase
    held           = bytes_held(span);
    res.used_count = SZ_W'(held);
    res.free_count = SZ_W'(span - held);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting, watchdog, receiver and result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch at result %0d: %s", $time, result_count, what);
  endtask

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Count down a requested hold-off; only this process writes hold_left.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drive out ready at the falling edge: held low during a hold-off, else switch
  // between always-ready runs, coin-flip stalls and a repeating 8-bit stall pattern.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 2));
      rx_left    = $urandom_range(16, 160);
      rx_pattern = 8'($urandom) | 8'h01;
    end
    rx_left--;
    rx_phase++;
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ch.ready = 1'b1;
        RX_RANDOM: out_ch.ready = 1'($urandom_range(0, 1));
        default:   out_ch.ready = rx_pattern[rx_phase % 8];
      endcase
    end
  end

  // Compare each result transaction with the oldest pending outcome.
  always @(posedge clk) begin
    fifo_outcome_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none pending (status %0d used %0d)",
                                  out_ch.status, out_ch.used_count));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte got %0h want %0h",
                                    out_ch.read_byte, want.read_byte));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
        if (out_ch.used_count !== want.used_count)
          report_mismatch($sformatf("used_count got %0d want %0d",
                                    out_ch.used_count, want.used_count));
        if (out_ch.free_count !== want.free_count)
          report_mismatch($sformatf("free_count got %0d want %0d",
                                    out_ch.free_count, want.free_count));
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------------

  // Offer one operation. Open a random gap at the end of each burst, hold
  // valid high until the block takes the transaction, then log its outcome.
  task automatic send_op(input logic [OPC_W-1:0]  op,
                         input logic [BYTE_W-1:0] data,
                         input logic [OFS_W-1:0]  ofs,
                         input logic [CNT_W-1:0]  cnt);
    @(negedge clk);
    if (sender_gaps && burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_ch.valid       = 1'b1;
    in_ch.opcode      = op;
    in_ch.data_byte   = data;
    in_ch.peek_offset = ofs;
    in_ch.erase_count = cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_outcomes.push_back(fifo_op_outcome(op, data, ofs, cnt));
  endtask

  // Drop valid and let every pending result come back, plus a short margin
  // for the two-stage pipe.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program the ring size only once the block is idle.
  task automatic write_ring_size(input logic [SZ_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.ring_size = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    apply_ring_size(value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Pick an erase count: mostly partial trims, plus zero, the full 256,
  // exactly the held count and exactly the head position.
  function automatic logic [CNT_W-1:0] pick_erase_count(input int unsigned held);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd256;
      2:       return CNT_W'(held);
      3:       return CNT_W'(head_ptr);
      default: return (held > 1) ? CNT_W'($urandom_range(1, held - 1))
                                 : CNT_W'($urandom_range(0, 256));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty ring at reset size: pops, peeks and trims must all be harmless.
  task automatic test_empty_ring();
    send_op(OP_READ,       8'h00, 8'h00, 9'd0);
    send_op(OP_PEEK,       8'h00, 8'h00, 9'd0);
    send_op(OP_DROP_FRONT, 8'h00, 8'h00, 9'd0);
    send_op(OP_DROP_BACK,  8'h00, 8'h00, 9'd5);
    send_op(OP_UNUSED_LO,  8'hFF, 8'hFF, 9'h1FF);
    send_op(OP_UNUSED_HI,  8'h00, 8'h00, 9'd0);
  endtask

  // Four-entry ring: fill, overflow, peek edges, then wrap the tail past the
  // head and trim the back by exactly the head so the head lands on zero.
  task automatic test_full_and_wrap();
    write_ring_size(9'd4);
    send_op(OP_WRITE,     8'h00, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'hFF, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'hA5, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'h5A, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'h3C, 8'h00, 9'd0);
    send_op(OP_PEEK,      8'h00, 8'd3,  9'd0);
    send_op(OP_PEEK,      8'h00, 8'd4,  9'd0);
    send_op(OP_PEEK,      8'h00, 8'd255, 9'd0);
    repeat (3) send_op(OP_READ, 8'h00, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'h11, 8'h00, 9'd0);
    send_op(OP_WRITE,     8'h22, 8'h00, 9'd0);
    send_op(OP_DROP_BACK, 8'h00, 8'h00, 9'd2);
    send_op(OP_PEEK,      8'h00, 8'd0,  9'd0);
    send_op(OP_DROP_BACK, 8'h00, 8'h00, 9'd1);
  endtask

  // Out-of-range sizes clamp; a size write empties the ring.
  task automatic test_size_limits();
    write_ring_size(9'd0);
    send_op(OP_WRITE,      8'h81, 8'h00, 9'd0);
    send_op(OP_WRITE,      8'h42, 8'h00, 9'd0);
    send_op(OP_DROP_FRONT, 8'h00, 8'h00, 9'd1);
    write_ring_size(9'h1FF);
    send_op(OP_WRITE,      8'h80, 8'h00, 9'd0);
    write_ring_size(RING_SIZE_RST);
    send_op(OP_READ,       8'h00, 8'h00, 9'd0);
  endtask

  // Stall the receiver for a long stretch while writes keep coming, so the
  // pipe fills and in ready drops; then let it drain.
  task automatic test_backpressure();
    write_ring_size(RING_SIZE_RST);
    sender_gaps = 1'b0;
    @(negedge clk);
    hold_len = HOLD_CYCLES;
    hold_token++;
    repeat (48) send_op(OP_WRITE, BYTE_W'($urandom), 8'h00, 9'd0);
    repeat (16) send_op(OP_PEEK, 8'h00, OFS_W'($urandom_range(0, 63)), 9'd0);
    sender_gaps = 1'b1;
  endtask

  // Mostly coherent traffic: alternate fill and drain phases with random
  // data, in-range peeks and partial trims, plus out-of-range noise.
  task automatic run_random_ops(input int unsigned count);
    bit                filling;
    int unsigned       span;
    int unsigned       held;
    int unsigned       pick;
    logic [OPC_W-1:0]  op;
    logic [OFS_W-1:0]  ofs;
    filling = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      span = ring_span();
      held = bytes_held(span);
      if (held == span) filling = 1'b0;
      else if (held == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (filling)
        op = (pick < 60) ? OP_WRITE : (pick < 72) ? OP_READ : (pick < 94) ? OP_PEEK :
             (pick < 97) ? OP_DROP_FRONT : OP_DROP_BACK;
      else
        op = (pick < 20) ? OP_WRITE : (pick < 50) ? OP_READ : (pick < 75) ? OP_PEEK :
             (pick < 88) ? OP_DROP_FRONT : OP_DROP_BACK;
      ofs = (held != 0 && $urandom_range(0, 4) != 0) ? OFS_W'($urandom_range(0, held - 1))
                                                     : OFS_W'($urandom_range(0, 255));
      send_op(op, BYTE_W'($urandom), ofs, pick_erase_count(held));
    end
  endtask

  // Sweep ring sizes from the one-entry ring to the full depth.
  task automatic test_random_traffic();
    int unsigned sizes  [6] = '{1, 2, 7, 33, 200, 256};
    int unsigned counts [6] = '{120, 150, 200, 250, 350, 430};
    for (int k = 0; k < 6; k++) begin
      write_ring_size(SZ_W'(sizes[k]));
      sender_gaps = (k % 3) != 2;
      run_random_ops(counts[k]);
    end
    sender_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.data_byte   = '0;
    in_ch.peek_offset = '0;
    in_ch.erase_count = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.ring_size  = RING_SIZE_RST;
    rst_n             = 1'b0;
    apply_ring_size(RING_SIZE_RST);

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_ring();
    test_full_and_wrap();
    test_size_limits();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
